[sv/sfr_pkg.sv]
// shared types and constants for the sync-framed byte receiver
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

  // holds any frame length up to the largest supported payload limit (64)
  localparam int LEN_W  = 7;
  // fill position wraps at 6 bits
  localparam int FILL_W = 6;

  // configuration register indexes
  localparam logic [0:0] REG_FIRST_SYNC  = 1'd0;
  localparam logic [0:0] REG_SECOND_SYNC = 1'd1;

  localparam logic [7:0] FIRST_SYNC_RST  = 8'd188;
  localparam logic [7:0] SECOND_SYNC_RST = 8'd207;

  // input item kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } sfr_in_t;

  typedef struct packed {
    logic [7:0] frame_type;
    logic [5:0] frame_length;
    logic [7:0] payload_byte;
    logic [4:0] payload_index;
    logic       last;
  } sfr_out_t;

  // good-frame notice from parser to drain unit
  typedef struct packed {
    logic             start;
    logic [7:0]       ftype;
    logic [LEN_W-1:0] flen;
  } sfr_frame_t;

  typedef enum logic [6:0] {
    PH_SYNC1 = 7'b0000001,
    PH_SYNC2 = 7'b0000010,
    PH_TYPE  = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_DATA  = 7'b0010000,
    PH_CK1   = 7'b0100000,
    PH_CK2   = 7'b1000000
  } sfr_phase_t;

  typedef enum logic [2:0] {
    DR_IDLE = 3'b001,
    DR_READ = 3'b010,
    DR_LOAD = 3'b100
  } sfr_drain_t;

endpackage

`default_nettype wire

[sv/sfr_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/sfr_parser.sv]
// frame parser: sync hunt, header, payload store writes and checksum
// depends on sfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfr_parser #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       first_sync,
  input  wire logic [7:0]       second_sync,
  input  wire logic             in_fire,
  input  wire sfr_pkg::sfr_in_t in_item,
  output logic                  ram_we,
  output logic [AW-1:0]         ram_waddr,
  output logic [7:0]            ram_wdata,
  output sfr_pkg::sfr_frame_t   frame
);

  import sfr_pkg::*;

  localparam logic [7:0]        MAX_B = 8'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0]  MAX_L = LEN_W'(MAX_PAYLOAD);

  sfr_phase_t        phase, phase_next;
  logic [7:0]        sum_low, sum_high;
  logic [7:0]        held_type;
  logic [LEN_W-1:0]  held_length;
  logic [FILL_W-1:0] fill_position;

  logic [7:0]        c;
  logic [7:0]        add_low;
  logic [FILL_W-1:0] fill_inc;

  assign c        = in_item.rx_byte;
  assign add_low  = sum_low + c;
  assign fill_inc = fill_position + FILL_W'(1);

  always_comb begin
    phase_next = phase;
    if (in_item.kind == KIND_TIMEOUT) begin
      phase_next = PH_SYNC1;
    end else begin
      case (phase)
        PH_SYNC2: phase_next = (c == second_sync) ? PH_TYPE : PH_SYNC1;
        PH_TYPE:  phase_next = PH_LEN;
        PH_LEN: begin
          if (c > MAX_B)        phase_next = PH_SYNC1;
          else if (c == 8'd0)   phase_next = PH_CK1;
          else                  phase_next = PH_DATA;
        end
        PH_DATA: begin
          if (LEN_W'(fill_inc) >= held_length) phase_next = PH_CK1;
        end
        PH_CK1:   phase_next = (c == sum_low) ? PH_CK2 : PH_SYNC1;
        PH_CK2:   phase_next = PH_SYNC1;
        default:  phase_next = (c == first_sync) ? PH_SYNC2 : PH_SYNC1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SYNC1;
      sum_low       <= '0;
      sum_high      <= '0;
      held_type     <= '0;
      held_length   <= '0;
      fill_position <= '0;
    end else if (in_fire) begin
      phase <= phase_next;
      if (in_item.kind == KIND_BYTE) begin
        case (phase)
          PH_TYPE: begin
            held_type <= c;
            sum_low   <= c;
            sum_high  <= c;
          end
          PH_LEN: begin
            if (c <= MAX_B) begin
              held_length   <= c[LEN_W-1:0];
              sum_low       <= add_low;
              sum_high      <= sum_high + add_low;
              fill_position <= '0;
            end
          end
          PH_DATA: begin
            sum_low       <= add_low;
            sum_high      <= sum_high + add_low;
            fill_position <= fill_inc;
          end
          default: ;
        endcase
      end
    end
  end

  // payload bytes go straight into the store at the fill position
  assign ram_we    = in_fire && (in_item.kind == KIND_BYTE) && (phase == PH_DATA)
                     && (LEN_W'(fill_position) < MAX_L);
  assign ram_waddr = AW'(fill_position);
  assign ram_wdata = c;

  assign frame.start = in_fire && (in_item.kind == KIND_BYTE) && (phase == PH_CK2)
                       && (c == sum_high);
  assign frame.ftype = held_type;
  assign frame.flen  = held_length;

endmodule

`default_nettype wire

[sv/sfr_drain.sv]
// drain sequencer: reads the payload store and fills the output register
// depends on sfr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sfr_drain #(
  parameter int MAX_PAYLOAD = 32,
  parameter int AW          = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sfr_pkg::sfr_frame_t frame,
  output logic                     busy,
  output logic [AW-1:0]            ram_raddr,
  input  wire logic [7:0]          ram_rdata,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sfr_pkg::sfr_out_t        out_data
);

  import sfr_pkg::*;

  sfr_drain_t        mode;
  logic [LEN_W-1:0]  k;
  logic [7:0]        ftype;
  logic [LEN_W-1:0]  flen;
  logic              is_empty, is_last, load;
  logic [LEN_W-1:0]  k_inc;

  assign k_inc     = k + LEN_W'(1);
  assign is_empty  = (flen == '0);
  assign is_last   = is_empty || (k_inc == flen);
  assign load      = (mode == DR_LOAD) && (!out_valid || out_ready);
  assign busy      = (mode != DR_IDLE);
  assign ram_raddr = AW'(k);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= DR_IDLE;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (mode)
        DR_IDLE: begin
          if (frame.start) begin
            mode <= DR_READ;
            k    <= '0;
          end
        end
        DR_READ: mode <= DR_LOAD;
        DR_LOAD: begin
          if (load) begin
            k    <= k_inc;
            mode <= is_last ? DR_IDLE : DR_READ;
          end
        end
        default: mode <= DR_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mode == DR_IDLE && frame.start) begin
      ftype <= frame.ftype;
      flen  <= frame.flen;
    end
    if (load) begin
      out_data.frame_type    <= ftype;
      out_data.frame_length  <= flen[5:0];
      out_data.payload_byte  <= is_empty ? 8'd0 : ram_rdata;
      out_data.payload_index <= k[4:0];
      out_data.last          <= is_last;
    end
  end

endmodule

`default_nettype wire

[sv/sync_frame_receiver_fletcher8_core.sv]
// sync-framed byte receiver with 8-bit fletcher-style check, top level
// depends on sfr_pkg, sfr_ram, sfr_parser, sfr_drain
// input: one byte or timeout transaction per cycle while not draining
// output: each result takes a store read, then an output register load; a good second check
//   byte starts the drain, the next store read waits for the previous load, and a load waits
//   while out_valid is held without out_ready; no input is taken while a frame drains
// reset: synchronous; parser hunts for the first sync byte, sync bytes return to 188/207,
//   output register empties; the payload store is not cleared
`timescale 1ns / 1ps
`default_nettype none

module sync_frame_receiver_fletcher8_core #(
  parameter int MAX_PAYLOAD = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  // configuration write port
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [7:0]        cfg_data,
  // byte stream in
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sfr_pkg::sfr_in_t  in_data,
  // payload results out
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sfr_pkg::sfr_out_t      out_data
);

  import sfr_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]  first_sync, second_sync;
  logic        in_fire;
  logic        busy;
  sfr_frame_t  frame;
  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_rdata;

  // sync byte registers
  always_ff @(posedge clk) begin
    if (rst) begin
      first_sync  <= FIRST_SYNC_RST;
      second_sync <= SECOND_SYNC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIRST_SYNC:  first_sync  <= cfg_data;
        REG_SECOND_SYNC: second_sync <= cfg_data;
        default: ;
      endcase
    end
  end

  // the parser stalls while a good frame is being drained
  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;

  sfr_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AW         (AW)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .first_sync (first_sync),
    .second_sync(second_sync),
    .in_fire    (in_fire),
    .in_item    (in_data),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .frame      (frame)
  );

  // payload store: written by the parser, read by the drain unit;
  // the two never overlap since input stalls during a drain
  sfr_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  sfr_drain #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AW         (AW)
  ) u_drain (
    .clk      (clk),
    .rst      (rst),
    .frame    (frame),
    .busy     (busy),
    .ram_raddr(ram_raddr),
    .ram_rdata(ram_rdata),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

[tb/testbench.sv]
// self-checking testbench for sync_frame_receiver_fletcher8_core
// depends on sfr_pkg and the receiver rtl; a scoreboard class holds its own frame decoder
`timescale 1ns / 1ps

module testbench;
  import sfr_pkg::*;

  localparam int MAX_LEN = 32;

  // ways a generated frame can be broken on purpose
  typedef enum int {
    FRAME_OK,
    BAD_CHECK_LOW,
    BAD_CHECK_HIGH,
    CUT_BY_TIMEOUT,
    BAD_SECOND_SYNC,
    OVERSIZE_LEN
  } frame_flaw_t;

  // receiver back-pressure styles
  typedef enum int {
    RDY_ALWAYS,
    RDY_COIN,
    RDY_SPARSE,
    RDY_EVERY_THIRD
  } ready_mode_t;

  // decodes the accepted byte stream and keeps the payload results still owed
  class frame_scoreboard;
    logic [7:0] first_sync;
    logic [7:0] second_sync;
    sfr_phase_t phase;
    logic [7:0] sum_lo;
    logic [7:0] sum_hi;
    logic [7:0] held_type;
    logic [5:0] held_len;
    logic [5:0] fill_pos;
    logic [7:0] payload_copy [MAX_LEN];
    sfr_out_t   payload_due [$];
    int         errors;

    function new();
      first_sync  = FIRST_SYNC_RST;
      second_sync = SECOND_SYNC_RST;
      phase       = PH_SYNC1;
      sum_lo      = '0;
      sum_hi      = '0;
      held_type   = '0;
      held_len    = '0;
      fill_pos    = '0;
      errors      = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [7:0] val);
      if (idx == REG_FIRST_SYNC) first_sync = val;
      else if (idx == REG_SECOND_SYNC) second_sync = val;
    endfunction

    function void add_sums(logic [7:0] b);
      sum_lo = sum_lo + b;
      sum_hi = sum_hi + sum_lo;
    endfunction

    // queue the results a good frame drains into
    function void queue_frame();
      sfr_out_t r;
      if (held_len == 0) begin
        r = '{frame_type: held_type, frame_length: 6'd0, payload_byte: 8'd0,
              payload_index: 5'd0, last: 1'b1};
        payload_due.push_back(r);
      end else begin
        for (int k = 0; k < held_len && k < MAX_LEN; k++) begin
          r.frame_type    = held_type;
          r.frame_length  = held_len;
          r.payload_byte  = payload_copy[k];
          r.payload_index = 5'(k);
          r.last          = (k + 1 == held_len);
          payload_due.push_back(r);
        end
      end
    endfunction

    function void accept_rx(sfr_in_t it);
      logic [7:0] c;
      c = it.rx_byte;
      if (it.kind == KIND_TIMEOUT) begin
        phase = PH_SYNC1;
        return;
      end
      case (phase)
        PH_SYNC2: phase = (c == second_sync) ? PH_TYPE : PH_SYNC1;
        PH_TYPE: begin
          held_type = c;
          sum_lo    = c;
          sum_hi    = c;
          phase     = PH_LEN;
        end
        PH_LEN: begin
          if (c <= MAX_LEN) begin
            held_len = 6'(c);
            add_sums(c);
            fill_pos = '0;
            phase    = (c > 0) ? PH_DATA : PH_CK1;
          end else begin
            phase = PH_SYNC1;
          end
        end
        PH_DATA: begin
          if (fill_pos < MAX_LEN) payload_copy[fill_pos] = c;
          add_sums(c);
          fill_pos = fill_pos + 6'd1;
          if (fill_pos >= held_len) phase = PH_CK1;
        end
        PH_CK1: phase = (c == sum_lo) ? PH_CK2 : PH_SYNC1;
        PH_CK2: begin
          phase = PH_SYNC1;
          if (c == sum_hi) queue_frame();
        end
        default: phase = (c == first_sync) ? PH_SYNC2 : PH_SYNC1;
      endcase
    endfunction

    function void check_payload(sfr_out_t got);
      sfr_out_t exp;
      if (payload_due.size() == 0) begin
        $display("%0t: unexpected result: type %h len %0d byte %h idx %0d last %b", $time,
                 got.frame_type, got.frame_length, got.payload_byte, got.payload_index,
                 got.last);
        errors++;
        return;
      end
      exp = payload_due.pop_front();
      if (got !== exp) begin
        $display({"%0t: mismatch: expected type %h len %0d byte %h idx %0d last %b, ",
                  "got type %h len %0d byte %h idx %0d last %b"},
                 $time, exp.frame_type, exp.frame_length, exp.payload_byte, exp.payload_index,
                 exp.last, got.frame_type, got.frame_length, got.payload_byte,
                 got.payload_index, got.last);
        errors++;
      end
    endfunction

    function int pending();
      return payload_due.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [0:0] cfg_index = REG_FIRST_SYNC;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  sfr_in_t    in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  sfr_out_t   out_data;

  frame_scoreboard sb = new();

  // sender burst state
  int items_sent = 0;
  int burst_left = 5;

  // receiver stall state; hold_req is bumped by the main flow to ask for a long hold
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  ready_mode_t rdy_mode = RDY_ALWAYS;
  int          mode_left = 0;
  int          third_cnt = 0;

  sync_frame_receiver_fletcher8_core #(.MAX_PAYLOAD(MAX_LEN)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  // monitor: both handshakes are sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid === 1'b1 && out_ready) sb.check_payload(out_data);
      if (in_valid && in_ready === 1'b1) sb.accept_rx(in_data);
    end
  end

  // receiver: keeps each stall style for a random stretch; a long hold overrides it
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rdy_mode  = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 60);
      end
      mode_left--;
      case (rdy_mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RDY_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
        default: begin
          out_ready <= (third_cnt == 0);
          third_cnt = (third_cnt + 1) % 3;
        end
      endcase
    end
  end

  function automatic sfr_in_t rx_byte_item(logic [7:0] b);
    return '{kind: KIND_BYTE, rx_byte: b};
  endfunction

  // one transaction: offered at the falling edge, held until taken; bursts end in a gap
  task automatic send_item(input sfr_in_t it);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    items_sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      // now and then a long burst with no idling at all
      burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 20);
    end
  endtask

  // sender goes quiet until every owed result is out, then lets the parser settle
  task automatic drain_wait();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // builds sync, sync, type, length, payload, two check bytes, then breaks it as asked;
  // for an oversize frame flen is the length byte itself and nothing follows it
  task automatic send_frame(input logic [7:0] ftype, input int flen, input frame_flaw_t flaw,
                            input bit fixed_fill, input logic [7:0] fill_val);
    sfr_in_t    seq [$];
    sfr_in_t    tick;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [7:0] b;
    int         cut;
    seq.push_back(rx_byte_item(sb.first_sync));
    if (flaw == BAD_SECOND_SYNC)
      seq.push_back(rx_byte_item(sb.second_sync ^ 8'($urandom_range(1, 255))));
    else
      seq.push_back(rx_byte_item(sb.second_sync));
    seq.push_back(rx_byte_item(ftype));
    lo = ftype;
    hi = ftype;
    if (flaw == OVERSIZE_LEN) begin
      seq.push_back(rx_byte_item(8'(flen)));
    end else begin
      seq.push_back(rx_byte_item(8'(flen)));
      lo = lo + 8'(flen);
      hi = hi + lo;
      for (int k = 0; k < flen; k++) begin
        b = fixed_fill ? fill_val : 8'($urandom);
        seq.push_back(rx_byte_item(b));
        lo = lo + b;
        hi = hi + lo;
      end
      seq.push_back(rx_byte_item(flaw == BAD_CHECK_LOW ? lo ^ 8'($urandom_range(1, 255)) : lo));
      seq.push_back(rx_byte_item(flaw == BAD_CHECK_HIGH ? hi ^ 8'($urandom_range(1, 255)) : hi));
      if (flaw == CUT_BY_TIMEOUT) begin
        // timeout lands anywhere after the sync pair and ends the transaction list
        cut          = $urandom_range(2, seq.size() - 1);
        tick.kind    = KIND_TIMEOUT;
        tick.rx_byte = 8'($urandom);
        seq[cut]     = tick;
        while (seq.size() > cut + 1) void'(seq.pop_back());
      end
    end
    foreach (seq[i]) send_item(seq[i]);
  endtask

  // loose bytes: timeouts, sync look-alikes and random values
  task automatic send_noise(input int n);
    sfr_in_t it;
    int      r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      it.kind    = KIND_BYTE;
      it.rx_byte = 8'($urandom);
      if (r < 2) it.kind = KIND_TIMEOUT;
      else if (r < 4) it.rx_byte = sb.first_sync;
      else if (r == 4) it.rx_byte = sb.second_sync;
      send_item(it);
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    // mostly short frames keep the drain cheap; a few reach the limit
    if (r < 80) return $urandom_range(0, 4);
    if (r < 95) return $urandom_range(5, 12);
    return $urandom_range(13, MAX_LEN);
  endfunction

  // sync settings per random phase: both extremes, random, equal, and back to reset
  logic [7:0] first_set  [5];
  logic [7:0] second_set [5];

  initial begin
    sfr_in_t it;
    int      target;
    int      r;
    logic [7:0] same;

    same = 8'($urandom);
    first_set  = '{8'd0,   8'd255, 8'($urandom), same, FIRST_SYNC_RST};
    second_set = '{8'd255, 8'd0,   8'($urandom), same, SECOND_SYNC_RST};

    // reset held, then released
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // directed part under the reset sync values
    // timeout right after the first sync byte
    send_item(rx_byte_item(sb.first_sync));
    it.kind    = KIND_TIMEOUT;
    it.rx_byte = 8'hff;
    send_item(it);
    // second sync position holding the first sync value drops back to the hunt
    send_item(rx_byte_item(sb.first_sync));
    send_item(rx_byte_item(sb.first_sync));
    // empty good frame with the top type value: single result
    send_frame(8'hff, 0, FRAME_OK, 1'b0, 8'd0);
    // length one above the limit
    send_frame(8'h5a, MAX_LEN + 1, OVERSIZE_LEN, 1'b0, 8'd0);
    // bad low check, then bad high check with type zero
    send_frame(8'h3c, 0, BAD_CHECK_LOW, 1'b0, 8'd0);
    send_frame(8'h00, 0, BAD_CHECK_HIGH, 1'b0, 8'd0);

    // random part, one stretch per sync setting
    for (int ph = 0; ph < 5; ph++) begin
      drain_wait();
      write_reg(REG_FIRST_SYNC, first_set[ph]);
      write_reg(REG_SECOND_SYNC, second_set[ph]);
      target = items_sent + 28;
      if (ph == 0) begin
        // largest frame, all-ones payload
        send_frame(8'($urandom), MAX_LEN, FRAME_OK, 1'b1, 8'hff);
      end else if (ph == 1) begin
        // receiver holds off while the sender keeps offering: the drain backs up into input
        @(posedge clk);
        hold_req++;
        send_frame(8'($urandom), 12, FRAME_OK, 1'b0, 8'd0);
        send_frame(8'($urandom), 3, FRAME_OK, 1'b0, 8'd0);
      end else if (ph == 2) begin
        send_frame(8'h00, 20, FRAME_OK, 1'b1, 8'h00);
      end
      while (items_sent < target) begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          send_frame(8'($urandom), pick_len(), FRAME_OK, 1'b0, 8'd0);
        end else if (r < 85) begin
          case ($urandom_range(0, 4))
            0: send_frame(8'($urandom), pick_len(), BAD_CHECK_LOW, 1'b0, 8'd0);
            1: send_frame(8'($urandom), pick_len(), BAD_CHECK_HIGH, 1'b0, 8'd0);
            2: send_frame(8'($urandom), pick_len(), CUT_BY_TIMEOUT, 1'b0, 8'd0);
            3: send_frame(8'($urandom), pick_len(), BAD_SECOND_SYNC, 1'b0, 8'd0);
            default: send_frame(8'($urandom), $urandom_range(MAX_LEN + 1, 255),
                                OVERSIZE_LEN, 1'b0, 8'd0);
          endcase
        end else begin
          send_noise($urandom_range(1, 4));
          // a timeout now and then so the next frame starts from the hunt
          if ($urandom_range(0, 1) == 0) begin
            it.kind    = KIND_TIMEOUT;
            it.rx_byte = 8'($urandom);
            send_item(it);
          end
        end
        // one full pause mid-stream, with results still draining
        if (ph == 3 && items_sent >= target - 18 && items_sent < target - 10) drain_wait();
      end
    end

    // everything offered; wait for the tail of the drain, then settle
    drain_wait();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
